@@ design/bbve_pkg.sv @@
// shared constants and types for the bandwidth vote encoder
// no dependencies
package bbve_pkg;

    localparam int unsigned BwWidth    = 64;
    localparam int unsigned DivWidth   = 32;
    localparam int unsigned MulWidth   = 16;
    localparam int unsigned MaskWidth  = 14;
    localparam int unsigned CmdWidth   = 31;
    localparam int unsigned VoteXPos   = 14;
    localparam int unsigned CmdCommit  = 30;
    localparam int unsigned CmdValid   = 29;

    localparam logic [MulWidth-1:0]  VoteScale = 16'd1000;
    localparam logic [MaskWidth-1:0] VoteSat   = 14'h3FFF;

    // operation sequence for one node
    typedef enum logic [1:0] {
        OP_AVG  = 2'd0,
        OP_PEAK = 2'd1,
        OP_X    = 2'd2,
        OP_Y    = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

endpackage

@@ design/bus_bandwidth_vote_encoder_top.sv @@
// bandwidth vote encoder: bit-serial saturating multiplier and radix-2 divider
// depends on bbve_pkg
//
// usage
//   input channel (in_valid/in_ready) carries one bus node of a vote group per
//   transaction; output channel (out_valid/out_ready) carries one result per
//   group, produced only on the node flagged last_node
//   each node runs two multiply/divide pairs on one shared serial unit: a
//   multiply, then a check that may skip the divide, then a divide; a last
//   node in bandwidth mode runs two more pairs, and the output step then
//   loads the result register
//   in_ready is high only while the sequencer is idle; a finished result sits
//   in the output register, so the next node is taken while it waits
//   if the receiver stalls with a result still held, the next group end waits
//   in the output step until the register frees
//   reset clears the running maxima, the activity flag and the output valid flag
module bus_bandwidth_vote_encoder_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bbve_pkg::BwWidth-1:0]   node_average,
    input  logic [bbve_pkg::BwWidth-1:0]   node_peak,
    input  logic [15:0]                    bus_bytes,
    input  logic [7:0]                     channel_count,
    input  logic [15:0]                    group_width,
    input  logic [31:0]                    group_unit,
    input  logic [bbve_pkg::MaskWidth-1:0] enable_mask,
    input  logic                           keep_alive,
    input  logic                           commit_flag,
    input  logic                           last_node,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bbve_pkg::BwWidth-1:0]   vote_avg,
    output logic [bbve_pkg::BwWidth-1:0]   vote_peak,
    output logic [bbve_pkg::CmdWidth-1:0]  command_word
);

    bbve_pkg::state_t state_reg, state_next;
    bbve_pkg::op_t    op_reg, op_next;
    logic [5:0]       cnt_reg, cnt_next;

    logic [63:0] avg_reg, peak_reg;
    logic [15:0] width_reg, bus_reg;
    logic [23:0] bdiv_reg;
    logic [31:0] unit_reg;
    logic [13:0] mask_reg;
    logic        keep_reg, commit_reg, last_reg;

    logic [63:0] max_avg_reg, max_avg_next;
    logic [63:0] max_peak_reg, max_peak_next;
    logic        active_reg, active_next;
    logic [63:0] x_reg, x_next, y_reg, y_next;

    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] mplier_reg, mplier_next;
    logic [63:0] num_reg, num_next;
    logic [31:0] rem_reg, rem_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] vavg_reg, vavg_next, vpeak_reg, vpeak_next;
    logic [30:0] cmd_reg, cmd_next;

    logic        in_acc;
    logic [63:0] mcand;
    logic [31:0] dvsr;
    logic [65:0] mul_sum;
    logic [63:0] dvnd;
    logic [33:0] trial;
    logic        fin;
    logic [63:0] fin_val;
    logic [63:0] fx, fy;
    logic [13:0] sx, sy;

    assign in_ready = (state_reg == bbve_pkg::S_IDLE);
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        case (op_reg)
            bbve_pkg::OP_AVG:  mcand = avg_reg;
            bbve_pkg::OP_PEAK: mcand = peak_reg;
            bbve_pkg::OP_X:    mcand = max_avg_reg;
            default:           mcand = max_peak_reg;
        endcase
        case (op_reg)
            bbve_pkg::OP_AVG:  dvsr = {8'd0, bdiv_reg};
            bbve_pkg::OP_PEAK: dvsr = {16'd0, bus_reg};
            default:           dvsr = unit_reg;
        endcase
    end

    // msb-first shift and add, sticky overflow saturates
    assign mul_sum = {1'b0, acc_reg, 1'b0} + (mplier_reg[15] ? {2'b00, mcand} : 66'd0);
    assign dvnd    = ovf_reg ? {64{1'b1}} : acc_reg;
    assign trial   = {1'b0, rem_reg, num_reg[63]} - {2'b00, dvsr};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        mplier_next    = mplier_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        max_avg_next   = max_avg_reg;
        max_peak_next  = max_peak_reg;
        active_next    = active_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && !out_ready;
        vavg_next      = vavg_reg;
        vpeak_next     = vpeak_reg;
        cmd_next       = cmd_reg;
        fin            = 1'b0;
        fin_val        = '0;
        fx             = x_reg;
        fy             = y_reg;

        case (state_reg)
            bbve_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next  = bbve_pkg::S_MUL;
                    op_next     = bbve_pkg::OP_AVG;
                    cnt_next    = '0;
                    acc_next    = '0;
                    ovf_next    = 1'b0;
                    mplier_next = group_width;
                    if ((node_average != '0) || (node_peak != '0))
                        active_next = 1'b1;
                end
            end
            bbve_pkg::S_MUL:
            begin
                if (!ovf_reg)
                begin
                    acc_next = mul_sum[63:0];
                    ovf_next = (mul_sum[65:64] != 2'b00);
                end
                mplier_next = {mplier_reg[14:0], 1'b0};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'hF)
                    state_next = bbve_pkg::S_CHK;
            end
            bbve_pkg::S_CHK:
            begin
                if (dvsr == '0)
                begin
                    fin     = 1'b1;
                    fin_val = {64{1'b1}};
                end
                else if (dvnd == '0)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    num_next   = dvnd - 64'd1;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = bbve_pkg::S_DIV;
                end
            end
            bbve_pkg::S_DIV:
            begin
                if (!trial[33])
                    rem_next = trial[31:0];
                else
                    rem_next = {rem_reg[30:0], num_reg[63]};
                num_next = {num_reg[62:0], !trial[33]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    fin     = 1'b1;
                    fin_val = {num_reg[62:0], !trial[33]} + 64'd1;
                end
            end
            bbve_pkg::S_OUT:
            begin
                if (mask_reg != '0)
                begin
                    fx = keep_reg ? {50'd0, mask_reg} : 64'd0;
                    fy = (keep_reg || active_reg) ? {50'd0, mask_reg} : 64'd0;
                end
                else if (keep_reg && (x_reg == '0) && (y_reg == '0))
                begin
                    fx = 64'd1;
                    fy = 64'd1;
                end
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vavg_next      = fx;
                    vpeak_next     = fy;
                    cmd_next       = '0;
                    cmd_next[bbve_pkg::CmdCommit] = commit_reg;
                    cmd_next[bbve_pkg::CmdValid]  = (fx != '0) || (fy != '0);
                    cmd_next[27:14] = sx;
                    cmd_next[13:0]  = sy;
                    max_avg_next   = '0;
                    max_peak_next  = '0;
                    active_next    = 1'b0;
                    state_next     = bbve_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbve_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            cnt_next    = '0;
            acc_next    = '0;
            ovf_next    = 1'b0;
            mplier_next = bbve_pkg::VoteScale;
            state_next  = bbve_pkg::S_MUL;
            case (op_reg)
                bbve_pkg::OP_AVG:
                begin
                    if (fin_val > max_avg_reg)
                        max_avg_next = fin_val;
                    op_next     = bbve_pkg::OP_PEAK;
                    mplier_next = width_reg;
                end
                bbve_pkg::OP_PEAK:
                begin
                    if (fin_val > max_peak_reg)
                        max_peak_next = fin_val;
                    op_next = bbve_pkg::OP_X;
                    if (!last_reg)
                        state_next = bbve_pkg::S_IDLE;
                    else if (mask_reg != '0)
                        state_next = bbve_pkg::S_OUT;
                end
                bbve_pkg::OP_X:
                begin
                    x_next  = fin_val;
                    op_next = bbve_pkg::OP_Y;
                end
                default:
                begin
                    y_next     = fin_val;
                    state_next = bbve_pkg::S_OUT;
                end
            endcase
        end
    end

    // saturate each vote to the command field width
    assign sx = (fx > {50'd0, bbve_pkg::VoteSat}) ? bbve_pkg::VoteSat : fx[13:0];
    assign sy = (fy > {50'd0, bbve_pkg::VoteSat}) ? bbve_pkg::VoteSat : fy[13:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbve_pkg::S_IDLE;
            op_reg        <= bbve_pkg::OP_AVG;
            cnt_reg       <= '0;
            max_avg_reg   <= '0;
            max_peak_reg  <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            max_avg_reg   <= max_avg_next;
            max_peak_reg  <= max_peak_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        vavg_reg   <= vavg_next;
        vpeak_reg  <= vpeak_next;
        cmd_reg    <= cmd_next;
        if (in_acc)
        begin
            avg_reg    <= node_average;
            peak_reg   <= node_peak;
            width_reg  <= group_width;
            bus_reg    <= bus_bytes;
            bdiv_reg   <= {8'd0, bus_bytes} * {16'd0, channel_count};
            unit_reg   <= group_unit;
            mask_reg   <= enable_mask;
            keep_reg   <= keep_alive;
            commit_reg <= commit_flag;
            last_reg   <= last_node;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vote_avg     = vavg_reg;
    assign vote_peak    = vpeak_reg;
    assign command_word = cmd_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bbve_pkg::S_IDLE) |-> !in_ready)
        else $error("input taken while sequencer busy");

    a_cmd_valid_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_word[bbve_pkg::CmdValid] ==
                       ((vote_avg != '0) || (vote_peak != '0))))
        else $error("command valid bit disagrees with votes");

    a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (!active_reg && (max_avg_reg == '0)))
        else $error("group state not cleared after result");

endmodule
